// ===== hw/rtl/lbs_pkg.sv =====
package lbs_pkg;

	localparam int WORDS_PER_BONE = 12;
	localparam int ACC_W          = 48;
	localparam int UNIT_W         = 18;
	localparam int S_TDATA_W      = 256;
	localparam int M_TDATA_W      = 152;
	localparam int TAB_ADDR_W     = 10;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_SKIN  = 1'b1;

	localparam logic [16:0] ONE_WEIGHT = 17'd65536;

	typedef struct packed {
		logic       load;
		logic       write;
		logic       rd;
		logic [3:0] word;
		logic [1:0] row;
		logic [1:0] tap;
		logic       mul;
		logic       add;
		logic       wgt;
		logic       weighted;
		logic       acc;
		logic       mag;
		logic       scale;
		logic       sq;
		logic       sqa;
		logic       sqrt_step;
		logic       div_init;
		logic       div_step;
		logic       div_store;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic zero;
		logic in_range;
	} status_t;

endpackage

// ===== hw/rtl/linear_blend_skinning_top.sv =====
// Linear blend skinning unit.
// Slave channel s_*: one request per item. s_tuser selects the kind: a bone
// table write (0) or a skin influence (1). s_tlast marks that further
// influences of the same vertex follow. Bone words are written in the
// request's accept cycle and the block is ready again on the next cycle.
// Each influence, after its accept cycle, makes 12 table reads through
// the single read port of the bone memory, each read followed by a multiply
// step, 9 add steps, and a weight and an accumulate step per row.
// The last influence of a vertex adds normalization of the summed normal:
// a magnitude step, scaling shifts until the magnitudes are in range, the
// sum of squares, a bit-serial square root and three bit-serial divides,
// then one result on the master channel m_*. When the summed normal is
// zero, the result follows without the sum of squares, root or divides.
// Reset clears the accumulators and the output valid; the bone table is
// not cleared and must be written before it is used.
// A result waits in the output register while m_tready is low; the block
// takes further requests until it has the next result ready.
module linear_blend_skinning_top #(
	parameter int MAX_BONES = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// bone, src_pos_x/y/z, src_nrm_x/y/z, weight, word_select, word_value
	input  logic [lbs_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          s_tuser,  // operation
	input  logic                          s_tlast,  // more_follow
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// skin_x/y/z, unit_nx/ny/nz
	output logic [lbs_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                          m_tuser   // degenerate_normal
);

	lbs_pkg::cmd_t    cmd;
	lbs_pkg::status_t st;

	lbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op       (s_tuser),
		.more     (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	lbs_dp #(
		.MAX_BONES (MAX_BONES),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.cmd     (cmd),
		.st      (st),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule

// ===== hw/rtl/lbs_ctrl.sv =====
module lbs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic            op,
	input  logic            more,
	output logic            m_tvalid,
	input  logic            m_tready,
	input  lbs_pkg::status_t st,
	output lbs_pkg::cmd_t   cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_RD     = 4'd1;
	localparam logic [3:0] S_MUL    = 4'd2;
	localparam logic [3:0] S_ADD    = 4'd3;
	localparam logic [3:0] S_WGT    = 4'd4;
	localparam logic [3:0] S_ACC    = 4'd5;
	localparam logic [3:0] S_NMAG   = 4'd6;
	localparam logic [3:0] S_NSCALE = 4'd7;
	localparam logic [3:0] S_NSQ    = 4'd8;
	localparam logic [3:0] S_NSQA   = 4'd9;
	localparam logic [3:0] S_NSQRT  = 4'd10;
	localparam logic [3:0] S_NDL    = 4'd11;
	localparam logic [3:0] S_NDIV   = 4'd12;
	localparam logic [3:0] S_NDST   = 4'd13;
	localparam logic [3:0] S_DONE   = 4'd14;

	logic [3:0] state_q, state_d;
	logic [1:0] row_q, row_d, tap_q, tap_d;
	logic [4:0] cnt_q, cnt_d;
	logic       inprog_q, inprog_d, more_q, more_d, valid_q;

	assign m_tvalid = valid_q;

	always_comb begin
		state_d  = state_q;
		row_d    = row_q;
		tap_d    = tap_q;
		cnt_d    = cnt_q;
		inprog_d = inprog_q;
		more_d   = more_q;
		s_tready = 1'b0;
		cmd      = '0;
		cmd.row  = row_q;
		cmd.tap  = tap_q;
		cmd.word = (tap_q == 2'd0) ? {2'b00, row_q} : 4'(3 * tap_q) + {2'b00, row_q};
		cmd.weighted = inprog_q | more_q;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (op == lbs_pkg::OP_SKIN) begin
						cmd.load = 1'b1;
						more_d   = more;
						row_d    = 2'd0;
						tap_d    = 2'd0;
						state_d  = S_RD;
					end else begin
						cmd.write = 1'b1;
					end
				end
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				if (tap_q == 2'd0) begin
					tap_d   = 2'd1;
					state_d = S_RD;
				end else begin
					state_d = S_ADD;
				end
			end
			S_ADD: begin
				cmd.add = 1'b1;
				if (tap_q == 2'd3) begin
					state_d = S_WGT;
				end else begin
					tap_d   = tap_q + 2'd1;
					state_d = S_RD;
				end
			end
			S_WGT: begin
				cmd.wgt = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				if (row_q == 2'd2) begin
					if (more_q) begin
						inprog_d = 1'b1;
						state_d  = S_IDLE;
					end else begin
						state_d = S_NMAG;
					end
				end else begin
					row_d   = row_q + 2'd1;
					tap_d   = 2'd0;
					state_d = S_RD;
				end
			end
			S_NMAG: begin
				cmd.mag = 1'b1;
				state_d = S_NSCALE;
			end
			S_NSCALE: begin
				if (st.zero) begin
					state_d = S_DONE;
				end else if (st.in_range) begin
					row_d   = 2'd0;
					state_d = S_NSQ;
				end else begin
					cmd.scale = 1'b1;
				end
			end
			S_NSQ: begin
				cmd.sq  = 1'b1;
				state_d = S_NSQA;
			end
			S_NSQA: begin
				cmd.sqa = 1'b1;
				if (row_q == 2'd2) begin
					cnt_d   = 5'd30;
					state_d = S_NSQRT;
				end else begin
					row_d   = row_q + 2'd1;
					state_d = S_NSQ;
				end
			end
			S_NSQRT: begin
				cmd.sqrt_step = 1'b1;
				if (cnt_q == 5'd0) begin
					row_d   = 2'd0;
					state_d = S_NDL;
				end else begin
					cnt_d = cnt_q - 5'd1;
				end
			end
			S_NDL: begin
				cmd.div_init = 1'b1;
				cnt_d        = 5'd17;
				state_d      = S_NDIV;
			end
			S_NDIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == 5'd0) begin
					state_d = S_NDST;
				end else begin
					cnt_d = cnt_q - 5'd1;
				end
			end
			S_NDST: begin
				cmd.div_store = 1'b1;
				if (row_q == 2'd2) begin
					state_d = S_DONE;
				end else begin
					row_d   = row_q + 2'd1;
					state_d = S_NDL;
				end
			end
			S_DONE: begin
				// hold until the output register is free
				if (!valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					inprog_d     = 1'b0;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			row_q    <= 2'd0;
			tap_q    <= 2'd0;
			cnt_q    <= 5'd0;
			inprog_q <= 1'b0;
			more_q   <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			row_q    <= row_d;
			tap_q    <= tap_d;
			cnt_q    <= cnt_d;
			inprog_q <= inprog_d;
			more_q   <= more_d;
			if (cmd.out_load) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/lbs_dp.sv =====
module lbs_dp #(
	parameter int MAX_BONES = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [lbs_pkg::S_TDATA_W-1:0]    s_tdata,
	input  lbs_pkg::cmd_t                    cmd,
	output lbs_pkg::status_t                 st,
	output logic [lbs_pkg::M_TDATA_W-1:0]    m_tdata,
	output logic                             m_tuser
);

	localparam int DEPTH = MAX_BONES * lbs_pkg::WORDS_PER_BONE;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int AC    = lbs_pkg::ACC_W;
	localparam int UW    = lbs_pkg::UNIT_W;
	localparam logic signed [AC-1:0] ACC_MAX = {1'b0, {(AC-1){1'b1}}};
	localparam logic signed [AC-1:0] ACC_MIN = {1'b1, {(AC-1){1'b0}}};

	logic [31:0] mem [DEPTH];
	logic [31:0] mem_q;

	logic [5:0]  in_bone;
	logic [3:0]  in_sel;
	logic [lbs_pkg::TAB_ADDR_W-1:0] wr_addr, base_q;
	logic        bone_ok_q, rd_ok_q;

	logic signed [31:0] pos_q [3];
	logic signed [31:0] nrm_q [3];
	logic [16:0] w_q;

	logic signed [63:0] pp_q, pn_q;
	logic signed [59:0] tp_q, tn_q;
	logic signed [65:0] wp_q, wn_q;
	logic signed [AC-1:0] pacc_q [3];
	logic signed [AC-1:0] nacc_q [3];

	logic [AC-1:0] mag_q [3];
	logic [AC-1:0] all_mag;
	logic [59:0]   sq_q;
	logic [61:0]   ss_q;
	logic [32:0]   srem_q;
	logic [30:0]   root_q;
	logic [31:0]   drem_q;
	logic [17:0]   dlo_q, quo_q;
	logic [UW-1:0] unit_q [3];

	logic signed [31:0] m_word;
	logic [16:0] w_eff;
	logic signed [AC-1:0] tp_sat, tn_sat;
	logic signed [49:0] psum, nsum;
	logic [32:0] srem2, strial;
	logic [31:0] drem2;
	logic [17:0] qcap;
	logic [1:0]  c;

	function automatic logic signed [AC-1:0] sat_acc(input logic signed [59:0] v);
		if (v > 60'(ACC_MAX)) begin
			return ACC_MAX;
		end else if (v < 60'(ACC_MIN)) begin
			return ACC_MIN;
		end
		return v[AC-1:0];
	endfunction

	function automatic logic [31:0] sat32(input logic signed [AC-1:0] v);
		if (v > 48'sh7FFF_FFFF) begin
			return 32'h7FFF_FFFF;
		end else if (v < -48'sh8000_0000) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	assign in_bone = s_tdata[5:0];
	assign in_sel  = s_tdata[218:215];
	assign wr_addr = lbs_pkg::TAB_ADDR_W'(in_bone) * lbs_pkg::TAB_ADDR_W'(12)
		+ lbs_pkg::TAB_ADDR_W'(in_sel);

	// table write and registered read
	always_ff @(posedge clk) begin
		if (cmd.write && in_sel < 4'(lbs_pkg::WORDS_PER_BONE) && 32'(in_bone) < MAX_BONES) begin
			mem[AW'(wr_addr)] <= s_tdata[250:219];
		end
		if (cmd.rd) begin
			mem_q   <= mem[AW'(base_q + lbs_pkg::TAB_ADDR_W'(cmd.word))];
			rd_ok_q <= bone_ok_q;
		end
	end

	assign m_word = rd_ok_q ? mem_q : 32'sd0;
	assign c      = cmd.tap - 2'd1;
	assign w_eff  = (!cmd.weighted || w_q > lbs_pkg::ONE_WEIGHT) ? lbs_pkg::ONE_WEIGHT : w_q;
	assign tp_sat = sat_acc(tp_q);
	assign tn_sat = sat_acc(tn_q);
	assign psum   = 50'(pacc_q[cmd.row]) + 50'(wp_q >>> 16);
	assign nsum   = 50'(nacc_q[cmd.row]) + 50'(wn_q >>> 16);

	assign all_mag     = mag_q[0] | mag_q[1] | mag_q[2];
	assign st.zero     = (all_mag == '0);
	assign st.in_range = (all_mag[AC-1:30] == '0) && all_mag[29];

	assign srem2  = {srem_q[30:0], ss_q[61:60]};
	assign strial = {root_q, 2'b01};
	assign drem2  = {drem_q[30:0], dlo_q[17]};
	assign qcap   = (quo_q > 18'd65536) ? 18'd65536 : quo_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q    <= lbs_pkg::TAB_ADDR_W'(in_bone) * lbs_pkg::TAB_ADDR_W'(12);
			bone_ok_q <= 32'(in_bone) < MAX_BONES;
			pos_q[0]  <= s_tdata[37:6];
			pos_q[1]  <= s_tdata[69:38];
			pos_q[2]  <= s_tdata[101:70];
			nrm_q[0]  <= s_tdata[133:102];
			nrm_q[1]  <= s_tdata[165:134];
			nrm_q[2]  <= s_tdata[197:166];
			w_q       <= s_tdata[214:198];
		end
		if (cmd.mul) begin
			if (cmd.tap == 2'd0) begin
				tp_q <= 60'(m_word);
				tn_q <= '0;
			end else begin
				pp_q <= m_word * pos_q[c];
				pn_q <= m_word * nrm_q[c];
			end
		end
		if (cmd.add) begin
			tp_q <= tp_q + 60'(pp_q >>> FRAC_BITS);
			tn_q <= tn_q + 60'(pn_q >>> FRAC_BITS);
		end
		if (cmd.wgt) begin
			wp_q <= 66'(tp_sat) * $signed({1'b0, w_eff});
			wn_q <= 66'(tn_sat) * $signed({1'b0, w_eff});
		end
		if (cmd.mag) begin
			for (int i = 0; i < 3; i++) begin
				mag_q[i] <= nacc_q[i][AC-1] ? AC'(-nacc_q[i]) : nacc_q[i];
			end
			ss_q   <= '0;
			srem_q <= '0;
			root_q <= '0;
		end
		if (cmd.scale) begin
			for (int i = 0; i < 3; i++) begin
				mag_q[i] <= (all_mag[AC-1:30] != '0) ? (mag_q[i] >> 1) : (mag_q[i] << 1);
			end
		end
		if (cmd.sq) begin
			sq_q <= mag_q[cmd.row][29:0] * mag_q[cmd.row][29:0];
		end
		if (cmd.sqa) begin
			ss_q <= ss_q + 62'(sq_q);
		end
		if (cmd.sqrt_step) begin
			ss_q <= ss_q << 2;
			if (srem2 >= strial) begin
				srem_q <= srem2 - strial;
				root_q <= {root_q[29:0], 1'b1};
			end else begin
				srem_q <= srem2;
				root_q <= {root_q[29:0], 1'b0};
			end
		end
		if (cmd.div_init) begin
			drem_q <= 32'(mag_q[cmd.row][29:2]);
			dlo_q  <= {mag_q[cmd.row][1:0], 16'd0};
			quo_q  <= '0;
		end
		if (cmd.div_step) begin
			dlo_q <= dlo_q << 1;
			if (drem2 >= {1'b0, root_q}) begin
				drem_q <= drem2 - {1'b0, root_q};
				quo_q  <= {quo_q[16:0], 1'b1};
			end else begin
				drem_q <= drem2;
				quo_q  <= {quo_q[16:0], 1'b0};
			end
		end
		if (cmd.div_store) begin
			unit_q[cmd.row] <= nacc_q[cmd.row][AC-1] ? UW'(-qcap) : qcap;
		end
		if (cmd.out_load) begin
			m_tdata[31:0]    <= sat32(pacc_q[0]);
			m_tdata[63:32]   <= sat32(pacc_q[1]);
			m_tdata[95:64]   <= sat32(pacc_q[2]);
			m_tdata[113:96]  <= st.zero ? '0 : unit_q[0];
			m_tdata[131:114] <= st.zero ? '0 : unit_q[1];
			m_tdata[149:132] <= st.zero ? '0 : unit_q[2];
			m_tdata[151:150] <= 2'b00;
			m_tuser          <= st.zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				pacc_q[i] <= '0;
				nacc_q[i] <= '0;
			end
		end else if (cmd.out_load) begin
			for (int i = 0; i < 3; i++) begin
				pacc_q[i] <= '0;
				nacc_q[i] <= '0;
			end
		end else if (cmd.acc) begin
			pacc_q[cmd.row] <= sat_acc(60'(psum));
			nacc_q[cmd.row] <= sat_acc(60'(nsum));
		end
	end

endmodule

// ===== hw/rtl/lbs_checker.sv =====
module lbs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [lbs_pkg::S_TDATA_W-1:0] s_tdata,
	input logic                          s_tuser,
	input logic                          s_tlast,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [lbs_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                          m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[149:96] == '0)
		else $error("degenerate normal with nonzero components");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[113:96]) <= 18'sd65536)
			&& ($signed(m_tdata[113:96]) >= -18'sd65536)
			&& ($signed(m_tdata[131:114]) <= 18'sd65536)
			&& ($signed(m_tdata[131:114]) >= -18'sd65536)
			&& ($signed(m_tdata[149:132]) <= 18'sd65536)
			&& ($signed(m_tdata[149:132]) >= -18'sd65536))
		else $error("unit normal component out of range");

	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == lbs_pkg::OP_WRITE && !m_tvalid |=> !m_tvalid)
		else $error("table write produced a result");

endmodule

bind linear_blend_skinning_top lbs_checker u_lbs_checker (.*);
